### design/ipag_pkg.sv
// Shared types, constants and helper functions for the IPv6 probe address generator.
package ipag_pkg;

  // Table geometry: two banks of TABLE_DEPTH entries
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(2 * TABLE_DEPTH);
  localparam int MEM_DEPTH   = 2 * TABLE_DEPTH;

  // Configuration register indexes
  localparam logic [1:0] CFG_SRC_HIGH    = 2'd0;
  localparam logic [1:0] CFG_SRC_LOW     = 2'd1;
  localparam logic [1:0] CFG_BANK_PARITY = 2'd2;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  // Prefix rules and protocol constants
  localparam logic [6:0]  LONG_PREFIX = 7'd56;
  localparam logic [7:0]  HOP_LIMIT   = 8'hFF;
  localparam logic [31:0] HASH_SEED   = 32'h1111_2222;
  // ICMPv6 payload length 8, next header 58, echo request type 128
  localparam logic [21:0] CONST_SUM   = 22'h00_0008 + 22'h00_003A + 22'h00_8000;

  // One table entry, all six stores side by side
  typedef struct packed {
    logic [63:0] stub;
    logic [63:0] mask;
    logic [6:0]  len;
    logic [63:0] brute;
    logic [31:0] zero;
    logic [31:0] one;
  } entry_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Plain sum of the four 16-bit words of a 64-bit value
  function automatic logic [17:0] sum64(input logic [63:0] v);
    return 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
  endfunction

endpackage

### design/ipag_ram.sv
// Prefix table memory: one write port, one read port, registered read data.
module ipag_ram
  import ipag_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ipag_hash.sv
// MurmurHash3_x86_32 over three 32-bit blocks, one multiply per cycle.
module ipag_hash
  import ipag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] blk0,
  input  logic [31:0] blk1,
  input  logic [31:0] blk2,
  output logic        done,
  output logic [31:0] hash
);

  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_A    = 7'b0000010,
    H_B    = 7'b0000100,
    H_C    = 7'b0001000,
    H_F1   = 7'b0010000,
    H_F2   = 7'b0100000,
    H_F3   = 7'b1000000
  } hstate_t;

  hstate_t     state_r;
  logic [1:0]  blk_r;
  logic [31:0] k_r;
  logic [31:0] h_r;
  logic        done_r;
  logic [31:0] blk_sel;
  logic [31:0] hk;
  logic [31:0] t1;
  logic [31:0] t2;

  // Block mux and shared mixing terms
  always_comb begin
    case (blk_r)
      2'd0:    blk_sel = blk0;
      2'd1:    blk_sel = blk1;
      default: blk_sel = blk2;
    endcase
    hk = rotl32(h_r ^ k_r, 13);
    t1 = h_r ^ 32'd12;
    t1 = t1 ^ (t1 >> 16);
    t2 = h_r ^ (h_r >> 13);
  end

  // Step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
      blk_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (start) begin
            blk_r   <= 2'd0;
            state_r <= H_A;
          end
        end
        H_A:  state_r <= H_B;
        H_B:  state_r <= H_C;
        H_C: begin
          if (blk_r == 2'd2) begin
            state_r <= H_F1;
          end else begin
            blk_r   <= blk_r + 2'd1;
            state_r <= H_A;
          end
        end
        H_F1: state_r <= H_F2;
        H_F2: state_r <= H_F3;
        H_F3: begin
          done_r  <= 1'b1;
          state_r <= H_IDLE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      H_IDLE: if (start) h_r <= HASH_SEED;
      H_A:    k_r <= blk_sel * 32'hcc9e_2d51;
      H_B:    k_r <= rotl32(k_r, 15) * 32'h1b87_3593;
      H_C:    h_r <= (hk << 2) + hk + 32'he654_6b64;
      H_F1:   h_r <= t1 * 32'h85eb_ca6b;
      H_F2:   h_r <= t2 * 32'hc2b2_ae35;
      H_F3:   h_r <= h_r ^ (h_r >> 16);
      default: ;
    endcase
  end

  assign done = done_r;
  assign hash = h_r;

endmodule

### design/ipv6_probe_address_generator_core.sv
// Top level: prefix table update, probe address build, hash and checksum.
// A load item is written in its accept cycle; in_ready stays high after it.
// A probe passes modify, hash start, the 12-step hash, sum, fold and done before out_valid.
// One item is in work at a time; a waiting result does not block the next accept.
// Synchronous active-low reset clears control state and config registers;
// table contents are undefined until loaded.
module ipv6_probe_address_generator_core
  import ipag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_bank,
  input  logic [11:0] in_entry_index,
  input  logic [63:0] in_stub_value,
  input  logic [63:0] in_mask_value,
  input  logic [6:0]  in_length_value,
  input  logic [63:0] in_brute_start,
  input  logic [31:0] in_zero_budget,
  input  logic [31:0] in_one_budget,
  input  logic [63:0] in_random_prefix,
  input  logic [31:0] in_random_suffix,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_dest_high,
  output logic [63:0] out_dest_low,
  output logic [15:0] out_echo_id,
  output logic [15:0] out_echo_seq,
  output logic [15:0] out_echo_checksum
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_HSTRT = 7'b0000100,
    S_HASH  = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_FOLD  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [63:0]       src_high_r;
  logic [63:0]       src_low_r;
  logic              parity_r;
  logic [ADDR_W-1:0] addr_r;
  logic [11:0]       idx_r;
  logic [63:0]       rnd_r;
  logic [31:0]       suffix_r;
  logic [63:0]       prefix_r;
  logic [21:0]       acc_r;
  logic [15:0]       csum_r;
  logic [31:0]       hash_val;
  logic              hash_done;

  logic              out_valid_r;
  logic [63:0]       out_high_r;
  logic [63:0]       out_low_r;
  logic [15:0]       out_id_r;
  logic [15:0]       out_seq_r;
  logic [15:0]       out_csum_r;

  logic              accept;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] in_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  entry_t            rd;
  entry_t            upd;
  entry_t            load_entry;
  logic              long_pfx;
  logic [6:0]        next_len;
  logic [63:0]       sel_stub;
  logic [63:0]       sel_mask;
  logic [63:0]       sel_rnd;
  logic [63:0]       prefix_nxt;
  logic [15:0]       echo_id;
  logic [15:0]       echo_seq;
  logic [63:0]       dest_low;
  logic [16:0]       fold1;
  logic [15:0]       fold2;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Table address: the load bank or the inverted probe parity picks the half, index wraps at the depth
  always_comb begin
    slot = ADDR_W'(in_entry_index % TABLE_DEPTH);
    if (in_operation == OP_LOAD) begin
      in_addr = in_bank ? ADDR_W'(TABLE_DEPTH) + slot : slot;
    end else begin
      in_addr = parity_r ? slot : ADDR_W'(TABLE_DEPTH) + slot;
    end
  end

  assign load_entry = '{stub:  in_stub_value,  mask: in_mask_value,
                        len:   in_length_value, brute: in_brute_start,
                        zero:  in_zero_budget, one:  in_one_budget};

  // Entry update for a probe
  always_comb begin
    upd      = rd;
    long_pfx = rd.len > LONG_PREFIX;
    next_len = rd.len + 7'd1;
    sel_stub = rd.stub;
    sel_mask = rd.mask;
    sel_rnd  = rd.brute;
    if (long_pfx) begin
      upd.brute = rd.brute + 64'd1;
    end else begin
      sel_rnd  = rnd_r;
      sel_mask = {64{1'b1}} >> next_len;
      if (rd.zero != 32'd0) begin
        upd.zero = rd.zero - 32'd1;
      end else begin
        sel_stub = rd.stub | (64'd1 << (7'd64 - next_len));
        upd.one  = rd.one - 32'd1;
      end
    end
    prefix_nxt = sel_stub + (sel_mask & sel_rnd);
  end

  // Memory write mux: loads at accept, write-back in the modify cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = load_entry;
    if (accept && in_operation == OP_LOAD) begin
      mem_we = 1'b1;
    end else if (state_r == S_MOD) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = upd;
    end
  end

  ipag_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept && in_operation == OP_PROBE),
    .raddr (in_addr),
    .rdata (rd)
  );

  ipag_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_HSTRT),
    .blk0  (swap32(prefix_r[63:32])),
    .blk1  (swap32(prefix_r[31:0])),
    .blk2  (suffix_r),
    .done  (hash_done),
    .hash  (hash_val)
  );

  assign echo_id  = {8'd0, 4'd0, idx_r[11:8]};
  assign echo_seq = {idx_r[7:0], HOP_LIMIT};
  assign dest_low = {swap32(suffix_r), hash_val};
  assign fold1    = 17'(acc_r[15:0]) + 17'(acc_r[21:16]);
  assign fold2    = fold1[15:0] + 16'(fold1[16]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_high_r <= '0;
      src_low_r  <= '0;
      parity_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_HIGH:    src_high_r <= cfg_data;
        CFG_SRC_LOW:     src_low_r  <= cfg_data;
        CFG_BANK_PARITY: parity_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE:  if (accept && in_operation == OP_PROBE) state_r <= S_MOD;
        S_MOD:   state_r <= S_HSTRT;
        S_HSTRT: state_r <= S_HASH;
        S_HASH:  if (hash_done) state_r <= S_SUM;
        S_SUM:   state_r <= S_FOLD;
        S_FOLD:  state_r <= S_DONE;
        S_DONE:  if (!out_valid_r || out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      // Result valid: set from the done state, cleared when taken
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        addr_r   <= in_addr;
        idx_r    <= in_entry_index;
        rnd_r    <= in_random_prefix;
        suffix_r <= in_random_suffix;
      end
      S_MOD: begin
        prefix_r <= prefix_nxt;
        acc_r    <= 22'(sum64(src_high_r)) + 22'(sum64(src_low_r)) + CONST_SUM;
      end
      S_HSTRT: acc_r <= acc_r + 22'(sum64(prefix_r)) + 22'(echo_id) + 22'(echo_seq);
      S_SUM:   acc_r <= acc_r + 22'(sum64(dest_low));
      S_FOLD:  csum_r <= ~fold2;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_high_r <= prefix_r;
          out_low_r  <= dest_low;
          out_id_r   <= echo_id;
          out_seq_r  <= echo_seq;
          out_csum_r <= csum_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_dest_high     = out_high_r;
  assign out_dest_low      = out_low_r;
  assign out_echo_id       = out_id_r;
  assign out_echo_seq      = out_seq_r;
  assign out_echo_checksum = out_csum_r;

endmodule

### design/ipag_checker.sv
// Port-level checks for the probe address generator, bound to the top level.
module ipag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_dest_high,
  input logic [15:0] out_echo_seq
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_high))
    else $error("result dropped or changed while stalled");

  // An accepted probe leaves the block busy, with in_ready low
  a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation |=> !in_ready)
    else $error("accepted a second item during a probe");

  // A load item leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_operation |=> in_ready)
    else $error("load item stalled the input");

  // Echo sequence always ends in the hop limit byte
  a_seq_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_echo_seq[7:0] == 8'hFF)
    else $error("echo sequence low byte wrong");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind ipv6_probe_address_generator_core ipag_checker u_ipag_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_dest_high (out_dest_high),
  .out_echo_seq  (out_echo_seq)
);

### test/ipv6_probe_address_generator_core_test.sv
// Testbench for the IPv6 probe address generator core: random loads and probes against a predictor.
`timescale 1ns / 100ps

module ipv6_probe_address_generator_core_test;
  import ipag_pkg::*;

  localparam logic [1:0] CFG_SPARE   = 2'd3;   // unmapped register index
  localparam int         CYCLE_LIMIT = 600000;
  localparam int         SETTLE      = 25;
  localparam int         PHASE_ITEMS = 210;

  typedef struct {
    logic        op;
    logic        bank;
    logic [11:0] idx;
    logic [63:0] stub;
    logic [63:0] mask;
    logic [6:0]  len;
    logic [63:0] brute;
    logic [31:0] zero;
    logic [31:0] one;
    logic [63:0] rnd_prefix;
    logic [31:0] rnd_suffix;
  } probe_item_t;

  typedef struct {
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    logic [15:0] echo_checksum;
  } probe_result_t;

  // Prefix table mirror, address builder and queue of pending destinations
  class probe_scoreboard;
    logic [63:0]   stub_tab  [MEM_DEPTH];
    logic [63:0]   mask_tab  [MEM_DEPTH];
    logic [6:0]    len_tab   [MEM_DEPTH];
    logic [63:0]   brute_tab [MEM_DEPTH];
    logic [31:0]   zero_tab  [MEM_DEPTH];
    logic [31:0]   one_tab   [MEM_DEPTH];
    logic [63:0]   src_high, src_low;
    logic          parity;
    probe_result_t pending_dest[$];
    int            errors;

    function void set_reg(logic [1:0] index, logic [63:0] data);
      case (index)
        CFG_SRC_HIGH:    src_high = data;
        CFG_SRC_LOW:     src_low = data;
        CFG_BANK_PARITY: parity = data[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] bswap(logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function logic [31:0] mix(logic [31:0] h, logic [31:0] k);
      k = k * 32'hcc9e2d51;
      k = rol(k, 15);
      k = k * 32'h1b873593;
      h = h ^ k;
      h = rol(h, 13);
      return h * 32'd5 + 32'he6546b64;
    endfunction

    function logic [31:0] murmur12(logic [31:0] b0, logic [31:0] b1, logic [31:0] b2);
      logic [31:0] h;
      h = mix(mix(mix(32'h11112222, b0), b1), b2);
      h = h ^ 32'd12;
      h = h ^ (h >> 16);
      h = h * 32'h85ebca6b;
      h = h ^ (h >> 13);
      h = h * 32'hc2b2ae35;
      return h ^ (h >> 16);
    endfunction

    // one's complement add with end-around carry, word by word
    function logic [31:0] csum_add(logic [31:0] s, logic [15:0] w);
      s = s + w;
      if (s > 32'hFFFF) s = (s & 32'hFFFF) + (s >> 16);
      return s;
    endfunction

    function logic [31:0] csum_add64(logic [31:0] s, logic [63:0] v);
      for (int i = 3; i >= 0; i--) s = csum_add(s, v[i*16 +: 16]);
      return s;
    endfunction

    function void note_input(probe_item_t it);
      int            slot;
      logic [63:0]   stub, mask, rnd;
      int            nlen;
      probe_result_t r;
      logic [31:0]   s;
      if (it.op == OP_LOAD) begin
        slot = it.bank * TABLE_DEPTH + it.idx;
        stub_tab[slot]  = it.stub;
        mask_tab[slot]  = it.mask;
        len_tab[slot]   = it.len;
        brute_tab[slot] = it.brute;
        zero_tab[slot]  = it.zero;
        one_tab[slot]   = it.one;
        return;
      end
      slot = (parity ? 0 : 1) * TABLE_DEPTH + it.idx;
      if (len_tab[slot] > LONG_PREFIX) begin
        // long prefix: brute counter under the mask
        rnd = brute_tab[slot];
        brute_tab[slot] = rnd + 64'd1;
        stub = stub_tab[slot];
        mask = mask_tab[slot];
      end else begin
        nlen = len_tab[slot] + 1;
        rnd = it.rnd_prefix;
        mask = {64{1'b1}} >> nlen;
        if (zero_tab[slot] != 0) begin
          stub = stub_tab[slot];
          zero_tab[slot] = zero_tab[slot] - 32'd1;
        end else begin
          stub = stub_tab[slot] | (64'd1 << (64 - nlen));
          one_tab[slot] = one_tab[slot] - 32'd1;
        end
      end
      r.dest_high = stub + (mask & rnd);
      r.dest_low = {bswap(it.rnd_suffix),
                    murmur12(bswap(r.dest_high[63:32]), bswap(r.dest_high[31:0]),
                             it.rnd_suffix)};
      r.echo_id = {12'd0, it.idx[11:8]};
      r.echo_seq = {it.idx[7:0], 8'd0} + 16'd255;
      s = 0;
      s = csum_add64(s, src_high);
      s = csum_add64(s, src_low);
      s = csum_add64(s, r.dest_high);
      s = csum_add64(s, r.dest_low);
      s = csum_add(s, 16'h0008);
      s = csum_add(s, 16'h003A);
      s = csum_add(s, 16'h8000);
      s = csum_add(s, r.echo_id);
      s = csum_add(s, r.echo_seq);
      r.echo_checksum = ~s[15:0];
      pending_dest.push_back(r);
    endfunction

    function void check_result(probe_result_t got);
      probe_result_t e;
      if (pending_dest.size() == 0) begin
        $error("result with nothing expected: dest_high %h", got.dest_high);
        errors++;
        return;
      end
      e = pending_dest.pop_front();
      if (got.dest_high !== e.dest_high) begin
        $error("dest_high expected %h got %h", e.dest_high, got.dest_high); errors++;
      end
      if (got.dest_low !== e.dest_low) begin
        $error("dest_low expected %h got %h", e.dest_low, got.dest_low); errors++;
      end
      if (got.echo_id !== e.echo_id) begin
        $error("echo_id expected %h got %h", e.echo_id, got.echo_id); errors++;
      end
      if (got.echo_seq !== e.echo_seq) begin
        $error("echo_seq expected %h got %h", e.echo_seq, got.echo_seq); errors++;
      end
      if (got.echo_checksum !== e.echo_checksum) begin
        $error("echo_checksum expected %h got %h", e.echo_checksum, got.echo_checksum);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_ready;
  logic        in_operation, in_bank;
  logic [11:0] in_entry_index;
  logic [63:0] in_stub_value, in_mask_value, in_brute_start, in_random_prefix;
  logic [6:0]  in_length_value;
  logic [31:0] in_zero_budget, in_one_budget, in_random_suffix;
  logic        out_valid, out_ready;
  logic [63:0] out_dest_high, out_dest_low;
  logic [15:0] out_echo_id, out_echo_seq, out_echo_checksum;

  probe_scoreboard sb = new();
  int              cycles;
  bit              steady;          // no idling on either side when set
  int              stall_left;
  bit              loaded [MEM_DEPTH];
  int              loaded_q [2][$];
  probe_item_t     it;

  ipv6_probe_address_generator_core DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // result side: random stalls, check on every accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_dest_high, out_dest_low, out_echo_id, out_echo_seq,
                        out_echo_checksum});
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic write_reg(logic [1:0] index, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(index, data);
    @(posedge clk);
  endtask

  task automatic send(probe_item_t x);
    int gap;
    int slot;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= x.op;
    in_bank <= x.bank;
    in_entry_index <= x.idx;
    in_stub_value <= x.stub;
    in_mask_value <= x.mask;
    in_length_value <= x.len;
    in_brute_start <= x.brute;
    in_zero_budget <= x.zero;
    in_one_budget <= x.one;
    in_random_prefix <= x.rnd_prefix;
    in_random_suffix <= x.rnd_suffix;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    if (x.op == OP_LOAD) begin
      slot = x.bank * TABLE_DEPTH + x.idx;
      if (!loaded[slot]) begin
        loaded[slot] = 1;
        loaded_q[x.bank].push_back(x.idx);
      end
    end
  endtask

  // sender holds off until every destination is back, then the core settles
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_dest.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic probe_item_t make_load(logic bank, logic [11:0] idx, logic [6:0] len);
    probe_item_t x;
    x.op = OP_LOAD;
    x.bank = bank;
    x.idx = idx;
    x.stub = rand64();
    x.mask = rand64();
    x.len = len;
    x.brute = ($urandom_range(0, 7) == 0) ? 64'hFFFF_FFFF_FFFF_FFFE : rand64();
    x.zero = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3);
    x.one = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2);
    x.rnd_prefix = rand64();
    x.rnd_suffix = $urandom();
    return x;
  endfunction

  function automatic probe_item_t make_probe(logic [11:0] idx);
    probe_item_t x;
    x = make_load(1'($urandom_range(0, 1)), idx, 7'($urandom_range(0, 64)));
    x.op = OP_PROBE;
    return x;
  endfunction

  function automatic logic [6:0] pick_len();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd56;
      2: return 7'd57;
      3: return 7'd64;
      4: return 7'd55;
      default: return 7'($urandom_range(0, 64));
    endcase
  endfunction

  initial begin
    logic        pbank;
    logic [11:0] idx;
    cycles = 0;
    steady = 0;
    stall_left = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    in_bank = 1'b0;
    in_entry_index = '0;
    in_stub_value = '0;
    in_mask_value = '0;
    in_length_value = '0;
    in_brute_start = '0;
    in_zero_budget = '0;
    in_one_budget = '0;
    in_random_prefix = '0;
    in_random_suffix = '0;
    sb.src_high = '0;
    sb.src_low = '0;
    sb.parity = 1'b0;
    sb.errors = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-ones source, probe the current bank; spare index is ignored
    write_reg(CFG_SRC_HIGH, {64{1'b1}});
    write_reg(CFG_SRC_LOW, {64{1'b1}});
    write_reg(CFG_BANK_PARITY, 64'd1);
    write_reg(CFG_SPARE, rand64());

    // directed: corner lengths, wrapping budgets, brute and prefix overflow
    it = make_load(1'b0, 12'd0, 7'd0);
    it.zero = 0; it.one = 0; it.stub = {64{1'b1}};
    send(it);
    it = make_load(1'b0, 12'hFFF, 7'd64);
    it.brute = {64{1'b1}}; it.mask = {64{1'b1}}; it.stub = {64{1'b1}};
    send(it);
    it = make_load(1'b0, 12'h100, 7'd56);
    it.zero = 1; it.one = 32'hFFFF_FFFF;
    send(it);
    it = make_load(1'b0, 12'h0FF, 7'd57);
    it.mask = '0;
    send(it);
    it = make_load(1'b1, 12'd0, 7'd64);   // other bank, must not be seen
    send(it);
    for (int i = 0; i < 3; i++) begin
      it = make_probe(12'd0);
      it.rnd_prefix = {64{1'b1}}; it.rnd_suffix = {32{1'b1}};
      send(it);
      it = make_probe(12'hFFF);
      send(it);
      it = make_probe(12'h100);
      it.rnd_prefix = '0; it.rnd_suffix = '0;
      send(it);
      it = make_probe(12'h0FF);
      send(it);
    end
    drain();

    // random phases, each with its own setting
    for (int ph = 0; ph < 4; ph++) begin
      steady = (ph == 2);
      write_reg(CFG_SRC_HIGH, (ph == 1) ? 64'd0 : rand64());
      write_reg(CFG_SRC_LOW, (ph == 1) ? 64'd0 : rand64());
      write_reg(CFG_BANK_PARITY, 64'(ph[0]));
      pbank = ph[0] ? 1'b0 : 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (loaded_q[pbank].size() == 0 || $urandom_range(0, 9) < 3) begin
          // loads mostly into a small pool so probes revisit entries
          idx = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 15)) : 12'($urandom());
          it = make_load(($urandom_range(0, 3) != 0) ? pbank : ~pbank, idx, pick_len());
        end else begin
          idx = 12'(loaded_q[pbank][$urandom_range(0, loaded_q[pbank].size() - 1)]);
          it = make_probe(idx);
        end
        send(it);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending_dest.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### sim.f
design/ipag_pkg.sv
design/ipag_ram.sv
design/ipag_hash.sv
design/ipv6_probe_address_generator_core.sv
design/ipag_checker.sv
test/ipv6_probe_address_generator_core_test.sv
